[sv/magma_block_cipher_core_assert.svh]
// Assertion macros used by the port-level checker of the Magma cipher core.
`ifndef MAGMA_BLOCK_CIPHER_CORE_ASSERT_SVH
`define MAGMA_BLOCK_CIPHER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent starts in the next cycle.
`define MBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mbc_pkg.sv]
// Types, constants and round functions of the Magma block cipher core.
`timescale 1ns / 1ps
package mbc_pkg;

  localparam int ROUNDS      = 32;
  localparam int KEYS        = 8;
  localparam int ENC_SPLIT   = 24;
  localparam int DEC_SPLIT   = 8;
  localparam int KEY_IDX_W   = $clog2(KEYS);
  localparam int CFG_IDX_W   = KEY_IDX_W + 1;
  localparam int QUEUE_DEPTH = 2;
  // Accept edge to the edge that samples the result strobe.
  localparam int LATENCY     = ROUNDS + 1;

  typedef enum logic {
    MODE_DEC = 1'b0,
    MODE_ENC = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] left;
    logic [31:0] right;
  } blk_t;

  typedef logic [KEYS-1:0][31:0] key_bank_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Fixed substitution tables; table n serves nibble n from the LSB.
  localparam logic [3:0] SBOX [KEYS][16] = '{
    '{4'hC, 4'h4, 4'h6, 4'h2, 4'hA, 4'h5, 4'hB, 4'h9,
      4'hE, 4'h8, 4'hD, 4'h7, 4'h0, 4'h3, 4'hF, 4'h1},
    '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC,
      4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'h0, 4'hF},
    '{4'hB, 4'h3, 4'h5, 4'h8, 4'h2, 4'hF, 4'hA, 4'hD,
      4'hE, 4'h1, 4'h7, 4'h4, 4'hC, 4'h9, 4'h6, 4'h0},
    '{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6,
      4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB},
    '{4'h7, 4'hF, 4'h5, 4'hA, 4'h8, 4'h1, 4'h6, 4'hD,
      4'h0, 4'h9, 4'h3, 4'hE, 4'hB, 4'h4, 4'h2, 4'hC},
    '{4'h5, 4'hD, 4'hF, 4'h6, 4'h9, 4'h2, 4'hC, 4'hA,
      4'hB, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'hE, 4'h0},
    '{4'h8, 4'hE, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hC,
      4'hF, 4'h4, 4'hB, 4'h0, 4'hD, 4'hA, 4'h3, 4'h7},
    '{4'h1, 4'h7, 4'hE, 4'hD, 4'h0, 4'h5, 4'h8, 4'h3,
      4'h4, 4'hF, 4'hA, 4'h6, 4'h9, 4'hC, 4'hB, 4'h2}
  };

  // Key word used by a given round: forward order before the split round (ENC_SPLIT or DEC_SPLIT), reversed from it on.
  function automatic logic [KEY_IDX_W-1:0] key_index(input int rnd, input logic enc);
    logic [KEY_IDX_W-1:0] pos;
    int                   split;
    pos   = KEY_IDX_W'(rnd % KEYS);
    split = enc ? ENC_SPLIT : DEC_SPLIT;
    return (rnd < split) ? pos : KEY_IDX_W'(KEYS - 1) - pos;
  endfunction

  // Round function: modular key add, nibble substitution, rotate left by 11.
  function automatic logic [31:0] mg_g(input logic [31:0] x, input logic [31:0] k);
    logic [31:0] a;
    logic [31:0] s;
    a = x + k;
    for (int n = 0; n < KEYS; n++) begin
      s[4*n +: 4] = SBOX[n][a[4*n +: 4]];
    end
    return {s[20:0], s[31:21]};
  endfunction

  // One Feistel round; decryption runs the inverse form.
  function automatic blk_t round_fn(input blk_t b, input logic [31:0] k);
    blk_t        r;
    logic [31:0] f;
    f      = mg_g((b.mode == MODE_ENC) ? b.right : b.left, k);
    r.mode = b.mode;
    if (b.mode == MODE_ENC) begin
      r.left  = b.right;
      r.right = b.left ^ f;
    end else begin
      r.left  = b.right ^ f;
      r.right = b.left;
    end
    return r;
  endfunction

endpackage

[sv/mbc_queue.sv]
// Short queue of block words between the front and the round pipeline.
`timescale 1ns / 1ps
module mbc_queue
  import mbc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  blk_t    push_word,
  input  logic    pop,
  output blk_t    head_word,
  output q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  blk_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  assign head_word  = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

[sv/mbc_front.sv]
// Front end: key registers, command acceptance and block classification.
`timescale 1ns / 1ps
module mbc_front
  import mbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [31:0]          in_left_half,
  input  logic [31:0]          in_right_half,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  q_stat_t              q_stat,
  output logic                 push,
  output blk_t                 push_word,
  output key_bank_t            keys
);

  key_bank_t key_r;
  logic      key_hit;

  // Indexes past the last key word are dropped.
  assign key_hit   = (cfg_index[CFG_IDX_W-1:KEY_IDX_W] == '0);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready && key_hit) begin
      key_r[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign keys = key_r;

  // Accept a word whenever the queue has room and tag its direction.
  assign busy            = q_stat.full;
  assign push            = start && !busy;
  assign push_word.mode  = in_mode ? MODE_ENC : MODE_DEC;
  assign push_word.left  = in_left_half;
  assign push_word.right = in_right_half;

endmodule

[sv/mbc_back.sv]
// Back end: thirty-two registered Feistel round stages.
`timescale 1ns / 1ps
module mbc_back
  import mbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  blk_t        head_word,
  input  key_bank_t   keys,
  output logic        pop,
  output logic        out_strobe,
  output logic [31:0] out_left_out,
  output logic [31:0] out_right_out
);

  logic [ROUNDS-1:0] vld_r;
  blk_t              stg_r  [ROUNDS];
  blk_t              stg_in [ROUNDS];

  // The pipeline never stalls, so the head word is taken as soon as it shows.
  assign pop = !q_stat.empty;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    localparam logic [KEY_IDX_W-1:0] EncIdx = key_index(i, 1'b1);
    localparam logic [KEY_IDX_W-1:0] DecIdx = key_index(i, 1'b0);
    logic [31:0] rkey;

    if (i == 0) begin : g_first
      assign stg_in[i] = head_word;
    end else begin : g_next
      assign stg_in[i] = stg_r[i-1];
    end

    // Round key depends on the direction carried with the word.
    assign rkey = (stg_in[i].mode == MODE_ENC) ? keys[EncIdx] : keys[DecIdx];

    always_ff @(posedge clk) begin
      stg_r[i] <= round_fn(stg_in[i], rkey);
    end
  end

  // Valid bits travel alongside the stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ROUNDS-2:0], pop};
    end
  end

  assign out_strobe    = vld_r[ROUNDS-1];
  assign out_left_out  = stg_r[ROUNDS-1].left;
  assign out_right_out = stg_r[ROUNDS-1].right;

endmodule

[sv/magma_block_cipher_core.sv]
// Top level of the pipelined Magma (GOST 64-bit) block cipher core.
//
//   Channel   Handshake             Payload                            Direction
//   in_       start / busy          in_mode, in_left_half, in_right_half  into core
//   out_      out_strobe            out_left_out, out_right_out         out of core
//   cfg_      cfg_valid / cfg_ready cfg_index, cfg_data                into core
//
// One block word can be accepted every clock cycle while busy is low; each
// is registered in the input queue and then runs through 32 round stages,
// one Feistel round per stage, and its result word is shown on out_strobe as
// it leaves the last stage. Reset is synchronous and clears the keys, queue
// and stage valid bits; there is no clearing pass. The result side cannot
// stall, so busy stays low in normal operation.
`timescale 1ns / 1ps
module magma_block_cipher_core
  import mbc_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [31:0]          in_left_half,
  input  logic [31:0]          in_right_half,
  output logic                 out_strobe,
  output logic [31:0]          out_left_out,
  output logic [31:0]          out_right_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  q_stat_t   q_stat;
  logic      push;
  logic      pop;
  blk_t      push_word;
  blk_t      head_word;
  key_bank_t keys;

  mbc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_left_half (in_left_half),
    .in_right_half(in_right_half),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_stat       (q_stat),
    .push         (push),
    .push_word    (push_word),
    .keys         (keys)
  );

  mbc_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word(push_word),
    .pop      (pop),
    .head_word(head_word),
    .stat     (q_stat)
  );

  mbc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head_word    (head_word),
    .keys         (keys),
    .pop          (pop),
    .out_strobe   (out_strobe),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out)
  );

endmodule

[sv/mbc_checker.sv]
// Port-level checks of the Magma cipher core, bound to the top level.
`timescale 1ns / 1ps
`include "magma_block_cipher_core_assert.svh"
module mbc_checker
  import mbc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic cfg_valid,
  input logic cfg_ready
);

  // Every accepted word comes out of the pipeline as a result strobe.
  `MBC_ASSERT_IMP(a_accept_to_result, start && !busy, ##LATENCY out_strobe, "result missing")
  // No result appears without an accepted word behind it.
  `MBC_ASSERT_IMP(a_result_has_source, out_strobe, $past(start && !busy, LATENCY), "stray result")
  // The pipeline drains the queue every cycle, so it never fills up.
  `MBC_ASSERT_NXT(a_never_busy, 1'b1, !busy, "core stalled the command side")
  // Key writes are never held off.
  `MBC_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "key write refused")

endmodule

bind magma_block_cipher_core mbc_checker u_mbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

[tb/magma_block_cipher_core_checker.sv]
// Result checker for the Magma cipher core: predicts every accepted block word and compares.
`timescale 1ns / 1ps
module magma_block_cipher_core_checker
  import mbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_mode,
  input  logic [31:0]          in_left_half,
  input  logic [31:0]          in_right_half,
  input  logic                 out_strobe,
  input  logic [31:0]          out_left_out,
  input  logic [31:0]          out_right_out,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int NUM_ROUNDS     = 32;
  localparam int ENC_FWD_ROUNDS = 24;
  localparam int DEC_FWD_ROUNDS = 8;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } half_pair_t;

  // Substitution tables; table n serves nibble n counted from the LSB.
  localparam logic [3:0] SUBST [8][16] = '{
    '{4'hC, 4'h4, 4'h6, 4'h2, 4'hA, 4'h5, 4'hB, 4'h9, 4'hE, 4'h8, 4'hD, 4'h7, 4'h0, 4'h3, 4'hF, 4'h1},
    '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC, 4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'h0, 4'hF},
    '{4'hB, 4'h3, 4'h5, 4'h8, 4'h2, 4'hF, 4'hA, 4'hD, 4'hE, 4'h1, 4'h7, 4'h4, 4'hC, 4'h9, 4'h6, 4'h0},
    '{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6, 4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB},
    '{4'h7, 4'hF, 4'h5, 4'hA, 4'h8, 4'h1, 4'h6, 4'hD, 4'h0, 4'h9, 4'h3, 4'hE, 4'hB, 4'h4, 4'h2, 4'hC},
    '{4'h5, 4'hD, 4'hF, 4'h6, 4'h9, 4'h2, 4'hC, 4'hA, 4'hB, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'hE, 4'h0},
    '{4'h8, 4'hE, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hC, 4'hF, 4'h4, 4'hB, 4'h0, 4'hD, 4'hA, 4'h3, 4'h7},
    '{4'h1, 4'h7, 4'hE, 4'hD, 4'h0, 4'h5, 4'h8, 4'h3, 4'h4, 4'hF, 4'hA, 4'h6, 4'h9, 4'hC, 4'hB, 4'h2}
  };

  logic [31:0] key_shadow [KEYS];
  half_pair_t  cipher_results_q [$];
  int          mismatches;

  // Key add mod 2^32, nibble substitution, then rotate left by 11.
  function automatic logic [31:0] mix_word(input logic [31:0] x, input logic [31:0] k);
    logic [31:0] sum;
    logic [31:0] sub;
    sum = x + k;
    for (int n = 0; n < 8; n++) begin
      sub[4*n +: 4] = SUBST[n][sum[4*n +: 4]];
    end
    return (sub << 11) | (sub >> 21);
  endfunction

  // Full 32-round transform of one block under the shadow key.
  function automatic half_pair_t cipher_block(input mode_t mode, input logic [31:0] l,
                                              input logic [31:0] r);
    logic [31:0] lw;
    logic [31:0] rw;
    logic [31:0] nl;
    logic [31:0] k;
    int          fwd;
    int          kidx;
    lw  = l;
    rw  = r;
    fwd = (mode == MODE_ENC) ? ENC_FWD_ROUNDS : DEC_FWD_ROUNDS;
    for (int rd = 0; rd < NUM_ROUNDS; rd++) begin
      kidx = (rd < fwd) ? (rd % KEYS) : (KEYS - 1 - rd % KEYS);
      k    = key_shadow[kidx];
      if (mode == MODE_ENC) begin
        nl = rw;
        rw = lw ^ mix_word(rw, k);
      end else begin
        nl = rw ^ mix_word(lw, k);
        rw = lw;
      end
      lw = nl;
    end
    return '{left: lw, right: rw};
  endfunction

  // Track key writes, queue predictions on accepted words, check each result word.
  always @(posedge clk) begin : watch
    half_pair_t want;
    if (!rst_n) begin
      for (int i = 0; i < KEYS; i++) begin
        key_shadow[i] = '0;
      end
      cipher_results_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < KEYS) begin
        key_shadow[cfg_index[KEY_IDX_W-1:0]] = cfg_data;
      end
      if (start && !busy) begin
        cipher_results_q.insert(cipher_results_q.size(),
                                cipher_block(mode_t'(in_mode), in_left_half, in_right_half));
      end
      if (out_strobe) begin
        if (cipher_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result word with none pending: left %h right %h",
                     $time, out_left_out, out_right_out);
          end
        end else begin
          want = cipher_results_q.pop_front();
          if (want.left !== out_left_out || want.right !== out_right_out) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: result mismatch: want left %h right %h, got left %h right %h",
                       $time, want.left, want.right, out_left_out, out_right_out);
            end
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= cipher_results_q.size();
  end

endmodule

[tb/magma_block_cipher_core_tb.sv]
// Stimulus and verdict for the Magma cipher core, with the result checker beside it.
`timescale 1ns / 1ps
module magma_block_cipher_core_tb;
  import mbc_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = LATENCY + 8;
  localparam int CFG_IDX_LAST  = (1 << CFG_IDX_W) - 1;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_mode;
  logic [31:0]          in_left_half;
  logic [31:0]          in_right_half;
  logic                 out_strobe;
  logic [31:0]          out_left_out;
  logic [31:0]          out_right_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles;
  bit                   no_gaps;

  magma_block_cipher_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_left_half  (in_left_half),
    .in_right_half (in_right_half),
    .out_strobe    (out_strobe),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  magma_block_cipher_core_checker u_cipher_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_left_half  (in_left_half),
    .in_right_half (in_right_half),
    .out_strobe    (out_strobe),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one; none in a burst stretch.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random words with extra weight on all-zero, all-one, single-bit and single-clear-bit values.
  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom;
    if (roll < 78) return '0;
    if (roll < 86) return '1;
    if (roll < 94) return 32'h1 << $urandom_range(0, 31);
    return ~(32'h1 << $urandom_range(0, 31));
  endfunction

  // Offer one block word, wait for it to be taken, then maybe idle for a randomly picked gap.
  task automatic send_block(input mode_t mode, input logic [31:0] l, input logic [31:0] r);
    int gap;
    in_mode       <= mode;
    in_left_half  <= l;
    in_right_half <= r;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start         <= 1'b0;
      in_mode       <= 1'($urandom_range(0, 1));
      in_left_half  <= $urandom;
      in_right_half <= $urandom;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering words and wait until every result word has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all key words, then indexes past the key list, which must change nothing.
  task automatic load_key(input key_bank_t bank);
    for (int i = 0; i < KEYS; i++) begin
      write_reg(CFG_IDX_W'(i), bank[i]);
    end
    for (int i = KEYS; i <= CFG_IDX_LAST; i++) begin
      write_reg(CFG_IDX_W'(i), $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_block(mode_t'($urandom_range(0, 1)), pick_word(), pick_word());
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin : stimulus
    key_bank_t bank;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_mode       = MODE_DEC;
    in_left_half  = '0;
    in_right_half = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Key never written: the all-zero key from reset.
    send_block(MODE_ENC, 32'h0000_0000, 32'h0000_0000);
    send_block(MODE_DEC, 32'h0000_0000, 32'h0000_0000);
    send_block(MODE_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(MODE_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(MODE_ENC, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(MODE_DEC, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(MODE_ENC, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(MODE_DEC, 32'h8000_0000, 32'h0000_0001);
    send_block(MODE_ENC, 32'h0000_0001, 32'h8000_0000);
    drain();

    // All-ones key.
    load_key('1);
    send_block(MODE_ENC, 32'h0000_0000, 32'hFFFF_FFFF);
    send_block(MODE_DEC, 32'h0000_0000, 32'hFFFF_FFFF);
    send_block(MODE_ENC, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(MODE_DEC, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    // The standard's example key and block, forward and back.
    bank = {32'hfcfd_feff, 32'hf8f9_fafb, 32'hf4f5_f6f7, 32'hf0f1_f2f3,
            32'h3322_1100, 32'h7766_5544, 32'hbbaa_9988, 32'hffee_ddcc};
    load_key(bank);
    send_block(MODE_ENC, 32'hfedc_ba98, 32'h7654_3210);
    send_block(MODE_DEC, 32'h4ee9_01e5, 32'hc2d8_ca3d);
    drain();

    // Random blocks under a series of keys, ending on the all-zero key.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int i = 0; i < KEYS; i++) begin
        if (ph == RANDOM_PHASES - 1) bank[i] = '0;
        else if (ph == 3) bank[i] = (i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        else bank[i] = pick_word();
      end
      load_key(bank);
      run_random(RANDOM_ITEMS / RANDOM_PHASES);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/mbc_pkg.sv
sv/mbc_queue.sv
sv/mbc_front.sv
sv/mbc_back.sv
sv/magma_block_cipher_core.sv
sv/mbc_checker.sv
tb/magma_block_cipher_core_checker.sv
tb/magma_block_cipher_core_tb.sv
